@@ sv/ssdc_pkg.sv @@
// Shared types, protocol codes and digit word tables for the display controller.
package ssdc_pkg;

    localparam int DIGITS = 16;
    localparam int ADDR_W = $clog2(DIGITS);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [15:0]       t_word;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_COMMAND = 2'd0,
        PH_ADDRESS = 2'd1,
        PH_HIGH    = 2'd2,
        PH_LOW     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SRC_RESET = 2'd0,
        SRC_HEX   = 2'd1,
        SRC_MEM   = 2'd2
    } t_src;

    localparam logic [7:0] CMD_READ   = 8'd0;
    localparam logic [7:0] CMD_WRITE  = 8'd1;
    localparam logic [7:0] CMD_HEX    = 8'd2;
    localparam logic [7:0] CMD_SLOW   = 8'd3;
    localparam logic [7:0] CMD_NORMAL = 8'd4;

    localparam logic [7:0] REPLY_ERROR  = 8'hFF;
    localparam logic [7:0] REPLY_FILLER = 8'hA4;

    typedef struct packed {
        logic  we;
        logic  hex_load;
        t_addr addr;
        t_word data;
    } t_wr_req;

    function automatic t_word reset_word(input t_addr idx);
        t_word w;
        unique case (idx)
            t_addr'(0): w = 16'hDB00;
            t_addr'(1): w = 16'hDA00;
            default:    w = 16'h0000;
        endcase
        return w;
    endfunction

    function automatic t_word hex_word(input t_addr idx);
        t_word w;
        unique case (idx)
            4'h0: w = 16'hFC00;
            4'h1: w = 16'h6000;
            4'h2: w = 16'hDA00;
            4'h3: w = 16'hF200;
            4'h4: w = 16'h6600;
            4'h5: w = 16'hB600;
            4'h6: w = 16'hBE00;
            4'h7: w = 16'hE000;
            4'h8: w = 16'hFE00;
            4'h9: w = 16'hF600;
            4'hA: w = 16'hEE00;
            4'hB: w = 16'h3E00;
            4'hC: w = 16'h1A00;
            4'hD: w = 16'h7A00;
            4'hE: w = 16'h9E00;
            4'hF: w = 16'h8E00;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

@@ sv/spi_seven_segment_display_controller_core.sv @@
// Top level of the serial-port seven-segment display controller.
//
//  Channel | Handshake              | Word fields
//  --------+------------------------+------------------------------------------------
//  input   | i_in_valid / o_in_ready | i_operation, i_spi_byte
//  output  | o_out_valid / i_out_ready | o_reply_loaded, o_reply_byte, o_refresh,
//          |                        | o_segment_bits, o_digit_select, o_upper_colon,
//          |                        | o_lower_colon
//
// A word is taken into the input register and its result is then loaded into the output
// register; one word can enter every cycle while the output is not stalled.
// The digit memory read issues when a word is taken, using the state the word will see.
// Reset is synchronous and active low; the memory needs no clearing pass.
// While the output word is not taken, a full input register holds and input ready falls.
module spi_seven_segment_display_controller_core
    import ssdc_pkg::*;
#(
    parameter int SLOW_DIVIDE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_spi_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_reply_loaded,
    output logic [7:0]  o_reply_byte,
    output logic        o_refresh,
    output logic [11:0] o_segment_bits,
    output logic [15:0] o_digit_select,
    output logic        o_upper_colon,
    output logic        o_lower_colon
);

    localparam int TICK_W = (SLOW_DIVIDE > 2) ? $clog2(SLOW_DIVIDE) : 1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(SLOW_DIVIDE - 1);

    logic              r_in_valid;
    t_op               r_op;
    logic [7:0]        r_byte;

    t_phase            r_phase;
    t_phase            n_phase;
    logic              r_write;
    logic              n_write;
    t_addr             r_target;
    t_addr             n_target;
    logic              r_slow;
    logic              n_slow;
    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] n_tick;
    t_addr             r_shown;
    t_addr             n_shown;
    logic [1:0]        r_colon;
    logic [1:0]        n_colon;
    logic              r_first;
    logic              n_first;
    logic [7:0]        r_wr_high;
    logic [7:0]        n_wr_high;

    logic              r_out_valid;
    logic              r_reply_loaded;
    logic              n_reply_loaded;
    logic [7:0]        r_reply_byte;
    logic [7:0]        n_reply_byte;
    logic              r_refresh;
    logic              n_refresh;
    logic [11:0]       r_segment_bits;
    logic [11:0]       n_segment_bits;
    logic [15:0]       r_digit_select;
    logic [15:0]       n_digit_select;
    logic              r_upper_colon;
    logic              n_upper_colon;
    logic              r_lower_colon;
    logic              n_lower_colon;

    logic              advance;
    logic              commit;
    logic              in_take;
    t_wr_req           wr_req;
    t_addr             raddr_a;
    t_addr             raddr_b;
    t_word             word_a;
    t_word             word_b;
    t_word             shown_word;

    assign advance    = !r_out_valid || i_out_ready;
    assign commit     = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_phase        = r_phase;
        n_write        = r_write;
        n_target       = r_target;
        n_slow         = r_slow;
        n_tick         = r_tick;
        n_shown        = r_shown;
        n_colon        = r_colon;
        n_first        = r_first;
        n_wr_high      = r_wr_high;
        n_reply_loaded = 1'b0;
        n_reply_byte   = 8'h00;
        n_refresh      = 1'b0;
        n_segment_bits = 12'h000;
        n_digit_select = 16'h0000;
        n_upper_colon  = 1'b0;
        n_lower_colon  = 1'b0;
        wr_req         = '0;
        shown_word     = word_b;

        if (commit) begin
            unique case (r_op)
                OP_BYTE: begin
                    unique case (r_phase)
                        PH_COMMAND: begin
                            if (r_byte == CMD_READ || r_byte == CMD_WRITE) begin
                                n_write = r_byte[0];
                                n_phase = PH_ADDRESS;
                            end else if (r_byte == CMD_HEX) begin
                                wr_req.hex_load = 1'b1;
                            end else if (r_byte == CMD_SLOW) begin
                                n_slow = 1'b1;
                            end else if (r_byte == CMD_NORMAL) begin
                                n_slow = 1'b0;
                            end
                        end
                        PH_ADDRESS: begin
                            if (r_byte[7:ADDR_W] != '0) begin
                                n_reply_loaded = 1'b1;
                                n_reply_byte   = REPLY_ERROR;
                                n_phase        = PH_COMMAND;
                            end else begin
                                n_target = r_byte[ADDR_W-1:0];
                                n_phase  = PH_HIGH;
                                if (!r_write) begin
                                    n_reply_loaded = 1'b1;
                                    n_reply_byte   = word_a[15:8];
                                end
                            end
                        end
                        PH_HIGH: begin
                            if (!r_write) begin
                                n_reply_loaded = 1'b1;
                                n_reply_byte   = word_a[7:0];
                            end else begin
                                wr_req.we   = 1'b1;
                                wr_req.addr = r_target;
                                wr_req.data = {r_byte, 8'h00};
                                n_wr_high   = r_byte;
                            end
                            n_phase = PH_LOW;
                        end
                        PH_LOW: begin
                            // The word was set to the high byte in the previous phase.
                            if (!r_write) begin
                                n_reply_loaded = 1'b1;
                                n_reply_byte   = REPLY_FILLER;
                            end else begin
                                wr_req.we   = 1'b1;
                                wr_req.addr = r_target;
                                wr_req.data = {r_wr_high, r_byte};
                            end
                            n_phase = PH_COMMAND;
                        end
                        default: n_phase = PH_COMMAND;
                    endcase
                end
                OP_RELEASE: begin
                    n_phase = PH_COMMAND;
                end
                OP_TICK: begin
                    n_tick = (r_tick == TICK_LAST) ? '0 : r_tick + TICK_W'(1);
                    if (!r_slow || r_tick == TICK_LAST) begin
                        n_shown   = r_shown + t_addr'(1);
                        n_refresh = 1'b1;
                    end
                end
                OP_NONE: begin
                end
                default: begin
                end
            endcase

            if (r_first) begin
                n_first   = 1'b0;
                n_refresh = 1'b1;
            end

            if (n_refresh) begin
                // A hex load in this same word is not yet in the read data.
                if (wr_req.hex_load) begin
                    shown_word = hex_word(n_shown);
                end
                if (!n_shown[ADDR_W-1]) begin
                    n_colon = 2'b01;
                end else if (n_shown[ADDR_W-2] == 1'b0) begin
                    n_colon = 2'b10;
                end
                n_segment_bits = shown_word[15:4];
                n_digit_select = 16'(1) << n_shown;
                n_upper_colon  = n_colon[0];
                n_lower_colon  = n_colon[1];
            end
        end
    end

    // Read addresses are formed from the state the incoming word will see.
    assign raddr_a = (n_phase == PH_ADDRESS) ? i_spi_byte[ADDR_W-1:0] : n_target;
    assign raddr_b = n_shown + t_addr'(i_operation == OP_TICK);

    ssdc_word_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_req),
        .i_rd_en   (in_take),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_word_a  (word_a),
        .o_word_b  (word_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_COMMAND;
            r_write     <= 1'b0;
            r_target    <= '0;
            r_slow      <= 1'b0;
            r_tick      <= '0;
            r_shown     <= '0;
            r_colon     <= 2'b00;
            r_first     <= 1'b1;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            r_phase  <= n_phase;
            r_write  <= n_write;
            r_target <= n_target;
            r_slow   <= n_slow;
            r_tick   <= n_tick;
            r_shown  <= n_shown;
            r_colon  <= n_colon;
            r_first  <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= t_op'(i_operation);
            r_byte <= i_spi_byte;
        end
        r_wr_high <= n_wr_high;
        if (advance) begin
            r_reply_loaded <= n_reply_loaded;
            r_reply_byte   <= n_reply_byte;
            r_refresh      <= n_refresh;
            r_segment_bits <= n_segment_bits;
            r_digit_select <= n_digit_select;
            r_upper_colon  <= n_upper_colon;
            r_lower_colon  <= n_lower_colon;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_reply_loaded = r_reply_loaded;
    assign o_reply_byte   = r_reply_byte;
    assign o_refresh      = r_refresh;
    assign o_segment_bits = r_segment_bits;
    assign o_digit_select = r_digit_select;
    assign o_upper_colon  = r_upper_colon;
    assign o_lower_colon  = r_lower_colon;

    a_reply_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reply_loaded |-> o_reply_byte == 8'h00)
        else $error("reply byte set without a loaded reply");

    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_refresh |-> $onehot(o_digit_select))
        else $error("digit select is not one-hot on a refresh");

    a_drive_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_refresh |-> o_digit_select == 16'h0000 && o_segment_bits == 12'h000)
        else $error("drive outputs set without a refresh");

    a_colon_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_upper_colon && o_lower_colon))
        else $error("both colon rows enabled");

    a_first_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first && commit |=> r_out_valid && r_refresh && !r_first)
        else $error("first word after reset did not refresh");

endmodule

@@ sv/ssdc_word_store.sv @@
// Digit word memory with two registered read ports, write bypass and per-entry source flags.
module ssdc_word_store
    import ssdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_wr_req i_wr,
    input  logic    i_rd_en,
    input  t_addr   i_raddr_a,
    input  t_addr   i_raddr_b,
    output t_word   o_word_a,
    output t_word   o_word_b
);

    t_word r_mem [DIGITS];
    t_src  r_src [DIGITS];
    t_src  n_src [DIGITS];

    t_word r_rd_a;
    t_word r_rd_b;
    t_src  r_src_a;
    t_src  r_src_b;
    t_addr r_idx_a;
    t_addr r_idx_b;
    logic  r_byp_a;
    logic  r_byp_b;
    t_word r_wdat;

    function automatic t_word pick(input t_src s, input t_addr idx, input logic byp,
                                   input t_word mem_d, input t_word wd);
        t_word w;
        unique case (s)
            SRC_RESET: w = reset_word(idx);
            SRC_HEX:   w = hex_word(idx);
            SRC_MEM:   w = byp ? wd : mem_d;
            default:   w = mem_d;
        endcase
        return w;
    endfunction

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            n_src[i] = r_src[i];
            if (i_wr.hex_load) begin
                n_src[i] = SRC_HEX;
            end else if (i_wr.we && i_wr.addr == t_addr'(i)) begin
                n_src[i] = SRC_MEM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DIGITS; i++) begin
            if (!i_rst_n) begin
                r_src[i] <= SRC_RESET;
            end else begin
                r_src[i] <= n_src[i];
            end
        end
    end

    // The read registers load together with the next word, so a write at the
    // same edge is forwarded through the bypass flags.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a  <= r_mem[i_raddr_a];
            r_rd_b  <= r_mem[i_raddr_b];
            r_src_a <= n_src[i_raddr_a];
            r_src_b <= n_src[i_raddr_b];
            r_idx_a <= i_raddr_a;
            r_idx_b <= i_raddr_b;
            r_byp_a <= i_wr.we && (i_wr.addr == i_raddr_a);
            r_byp_b <= i_wr.we && (i_wr.addr == i_raddr_b);
            r_wdat  <= i_wr.data;
        end
    end

    assign o_word_a = pick(r_src_a, r_idx_a, r_byp_a, r_rd_a, r_wdat);
    assign o_word_b = pick(r_src_b, r_idx_b, r_byp_b, r_rd_b, r_wdat);

endmodule
